@@ src/efc_pkg.sv @@
// Shared types, constants and evidence tables of the evidence fusion classifier.
package efc_pkg;

   // Q16 masses, index 0 normal, 1 urine, 2 feces, 3 unknown (whole frame)
   typedef logic [3:0][15:0] mass_type;

   typedef struct packed {
      logic signed [11:0] temp_tenths;
      logic [9:0]         humidity_tenths;
      logic [13:0]        ammonia_tenths;
   } req_type;

   typedef struct packed {
      logic [1:0]  class_index;
      logic [15:0] belief_normal;
      logic [15:0] belief_urine;
      logic [15:0] belief_feces;
      logic [15:0] belief_unknown;
   } rsp_type;

   localparam logic CSR_TEMP_BASE = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   localparam logic [1:0] CLASS_NORMAL = 2'd0;
   localparam logic [1:0] CLASS_URINE  = 2'd1;
   localparam logic [1:0] CLASS_FECES  = 2'd2;

   localparam logic signed [12:0] TEMP_T0 = 13'sd5;
   localparam logic signed [12:0] TEMP_T1 = 13'sd20;
   localparam logic signed [12:0] TEMP_T2 = 13'sd40;
   localparam logic [9:0]  HUM_T0 = 10'd600;
   localparam logic [9:0]  HUM_T1 = 10'd750;
   localparam logic [9:0]  HUM_T2 = 10'd850;
   localparam logic [13:0] NH3_T0 = 14'd50;
   localparam logic [13:0] NH3_T1 = 14'd150;
   localparam logic [13:0] NH3_T2 = 14'd300;

   localparam logic [16:0] Q16_FULL = 17'd65536;
   localparam int FUSE_LATENCY = 6;

   function automatic mass_type temp_mass(input logic [1:0] b);
      mass_type m;
      case (b)
         2'd0: m = {16'd13107, 16'd3277, 16'd3277, 16'd45875};
         2'd1: m = {16'd19661, 16'd13107, 16'd13107, 16'd19661};
         2'd2: m = {16'd16384, 16'd13107, 16'd32768, 16'd3277};
         default: m = {16'd11796, 16'd16384, 16'd36045, 16'd1311};
      endcase
      return m;
   endfunction

   function automatic mass_type hum_mass(input logic [1:0] b);
      mass_type m;
      case (b)
         2'd0: m = {16'd9830, 16'd3277, 16'd3277, 16'd49152};
         2'd1: m = {16'd19661, 16'd9830, 16'd16384, 16'd19661};
         2'd2: m = {16'd16384, 16'd16384, 16'd29491, 16'd3277};
         default: m = {16'd11796, 16'd13107, 16'd39322, 16'd1311};
      endcase
      return m;
   endfunction

   function automatic mass_type nh3_mass(input logic [1:0] b);
      mass_type m;
      case (b)
         2'd0: m = {16'd8520, 16'd1311, 16'd3277, 16'd52429};
         2'd1: m = {16'd16384, 16'd6554, 16'd36045, 16'd6554};
         2'd2: m = {16'd14418, 16'd16384, 16'd32768, 16'd1966};
         default: m = {16'd15073, 16'd39322, 16'd9830, 16'd1311};
      endcase
      return m;
   endfunction

endpackage

@@ src/efc_fuse.sv @@
// Pipelined Dempster-Shafer combination of two Q16 mass functions (six stages).
module efc_fuse (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  efc_pkg::mass_type x,
   input  efc_pkg::mass_type y,
   output logic             out_valid,
   output efc_pkg::mass_type r
);
   import efc_pkg::*;

   localparam int DIV_STAGES = 4;
   localparam int BITS_PER_STAGE = 4;

   // stage A: truncated products
   logic [3:0][3:0][15:0] prod_ff, prod_in;
   logic                  va_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            logic [31:0] p;
            p = x[i] * y[j];
            prod_in[i][j] = p[31:16];
         end
      end
   end

   // stage B: focal sums, conflict, normalizer
   logic [3:0][17:0] num_ff, num_in;
   logic [16:0]      den_ff, den_in;
   logic             vb_ff;

   always_comb begin
      logic [18:0] conflict;
      conflict = '0;
      for (int i = 0; i < 3; i++) begin
         num_in[i] = 18'(prod_ff[i][i]) + 18'(prod_ff[i][3]) + 18'(prod_ff[3][i]);
         for (int j = 0; j < 3; j++) begin
            if (i != j) begin
               conflict = conflict + 19'(prod_ff[i][j]);
            end
         end
      end
      num_in[3] = 18'(prod_ff[3][3]);
      if (conflict >= 19'(Q16_FULL)) begin
         den_in = 17'd1;
      end else begin
         den_in = Q16_FULL - conflict[16:0];
      end
   end

   // stages D0..D3: restoring division, four quotient bits a stage
   logic [DIV_STAGES-1:0][3:0][16:0] rem_ff, rem_in;
   logic [DIV_STAGES-1:0][3:0][15:0] quo_ff, quo_in;
   logic [DIV_STAGES-1:0][3:0]       sat_ff, sat_in;
   logic [DIV_STAGES-1:0][16:0]      dd_ff, dd_in;
   logic [DIV_STAGES-1:0]            vd_ff;

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int k = 0; k < 4; k++) begin
            logic [16:0] rem;
            logic [15:0] quo;
            logic [17:0] sh;
            logic [16:0] den;
            if (s == 0) begin
               den = den_ff;
               sat_in[s][k] = (num_ff[k] >= 18'(den_ff));
               rem = sat_in[s][k] ? 17'd0 : num_ff[k][16:0];
               quo = '0;
            end else begin
               den = dd_ff[s-1];
               sat_in[s][k] = sat_ff[s-1][k];
               rem = rem_ff[s-1][k];
               quo = quo_ff[s-1][k];
            end
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
               sh = {rem, 1'b0};
               if (sh >= 18'(den)) begin
                  sh = sh - 18'(den);
                  quo = {quo[14:0], 1'b1};
               end else begin
                  quo = {quo[14:0], 1'b0};
               end
               rem = sh[16:0];
            end
            rem_in[s][k] = rem;
            quo_in[s][k] = quo;
         end
         dd_in[s] = (s == 0) ? den_ff : dd_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      sat_ff  <= sat_in;
      dd_ff   <= dd_in;
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vd_ff <= '0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vd_ff <= {vd_ff[DIV_STAGES-2:0], vb_ff};
      end
   end

   assign out_valid = vd_ff[DIV_STAGES-1];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         r[k] = sat_ff[DIV_STAGES-1][k] ? 16'hFFFF : quo_ff[DIV_STAGES-1][k];
      end
   end

endmodule

@@ src/evidence_fusion_classifier.sv @@
// Top level of the evidence fusion classifier: banding, two fusions, decision.
//
// Usage:
//  - Request channel: a request (temperature, humidity, ammonia in tenths)
//    is taken at every rising edge where start is high and busy is low.
//    busy is always low, so one request can enter every cycle.
//  - Result channel: rsp_valid is high for exactly one cycle with the
//    decided class and the four fused Q16 beliefs. The receiver cannot
//    stall; results simply leave the pipeline in request order.
//  - Pipeline from the accepting edge to the result: 1 banding stage,
//    6 per fusion unit and 1 decision stage.
//  - Throughput: one request per cycle, set by the fully pipelined fusion
//    units (16 multipliers and a 4-stage restoring divider per unit).
//  - CSR channel: csr_ready is always high; index 0 writes the temperature
//    baseline (low 12 bits), index 1 the decision threshold. Write only
//    while no request is in flight.
//  - Reset (synchronous) clears all valid bits and reloads baseline 300
//    and threshold 32768.
module evidence_fusion_classifier (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  efc_pkg::req_type req_data,
   output logic            rsp_valid,
   output efc_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [15:0]     csr_wdata
);
   import efc_pkg::*;

   localparam int LATENCY = 2 * FUSE_LATENCY + 2;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers
   logic signed [11:0] base_ff;
   logic [15:0]        thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 12'sd300;
         thr_ff  <= 16'd32768;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEMP_BASE: base_ff <= csr_wdata[11:0];
            CSR_THRESHOLD: thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 0: band each reading; delta is 13 bits so it never wraps
   logic [1:0] tb_in, hb_in, nb_in;
   logic [1:0] tb_ff, hb_ff, nb_ff;
   logic       v0_ff;

   always_comb begin
      logic signed [12:0] delta;
      delta = 13'(req_data.temp_tenths) - 13'(base_ff);
      if (delta < TEMP_T0)      tb_in = 2'd0;
      else if (delta < TEMP_T1) tb_in = 2'd1;
      else if (delta < TEMP_T2) tb_in = 2'd2;
      else                      tb_in = 2'd3;
      if (req_data.humidity_tenths < HUM_T0)      hb_in = 2'd0;
      else if (req_data.humidity_tenths < HUM_T1) hb_in = 2'd1;
      else if (req_data.humidity_tenths < HUM_T2) hb_in = 2'd2;
      else                                        hb_in = 2'd3;
      if (req_data.ammonia_tenths < NH3_T0)      nb_in = 2'd0;
      else if (req_data.ammonia_tenths < NH3_T1) nb_in = 2'd1;
      else if (req_data.ammonia_tenths < NH3_T2) nb_in = 2'd2;
      else                                       nb_in = 2'd3;
   end

   always_ff @(posedge clock) begin
      tb_ff <= tb_in;
      hb_ff <= hb_in;
      nb_ff <= nb_in;
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start && !busy;
   end

   // first fusion: temperature with humidity
   mass_type f1;
   logic     f1_valid;

   efc_fuse u_fuse_th (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .x         (temp_mass(tb_ff)),
      .y         (hum_mass(hb_ff)),
      .out_valid (f1_valid),
      .r         (f1)
   );

   // ammonia band rides alongside the first fusion
   logic [FUSE_LATENCY-1:0][1:0] nb_dly_ff;

   always_ff @(posedge clock) begin
      nb_dly_ff <= {nb_dly_ff[FUSE_LATENCY-2:0], nb_ff};
   end

   // second fusion: result with ammonia
   mass_type f2;
   logic     f2_valid;

   efc_fuse u_fuse_nh3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f1_valid),
      .x         (f1),
      .y         (nh3_mass(nb_dly_ff[FUSE_LATENCY-1])),
      .out_valid (f2_valid),
      .r         (f2)
   );

   // decision: largest belief, ties to the lower index, weak -> normal
   rsp_type rsp_ff, rsp_in;
   logic    rv_ff;

   always_comb begin
      logic [15:0] top;
      logic [1:0]  best;
      best = CLASS_NORMAL;
      top  = f2[0];
      if (f2[1] > top) begin
         best = CLASS_URINE;
         top  = f2[1];
      end
      if (f2[2] > top) begin
         best = CLASS_FECES;
         top  = f2[2];
      end
      if (top < thr_ff) best = CLASS_NORMAL;
      rsp_in.class_index    = best;
      rsp_in.belief_normal  = f2[0];
      rsp_in.belief_urine   = f2[1];
      rsp_in.belief_feces   = f2[2];
      rsp_in.belief_unknown = f2[3];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= f2_valid;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // every result traces back to a request a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without matching request");

   a_class_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.class_index != 2'd3))
      else $error("invalid class code");

   a_urine_thr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.class_index == CLASS_URINE |->
         rsp_data.belief_urine >= thr_ff)
      else $error("urine chosen below threshold");

   a_feces_thr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.class_index == CLASS_FECES |->
         rsp_data.belief_feces >= thr_ff && rsp_data.belief_feces > rsp_data.belief_urine)
      else $error("feces decision inconsistent");

endmodule
